>>> rtl/irws_pkg.sv
// Shared types and constants for the IR wall sensor sequencer.
`timescale 1ns / 1ps
package irws_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int ERR_W      = 14;
	localparam int ERR_LIMIT  = 8190;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT_THR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRONT_THR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_TARGET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TARGET = 3'd4;

	localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 12'd800;
	localparam logic [CFG_DATA_W-1:0] TARGET_RESET    = 12'd1400;

	localparam logic [1:0] PH_DARK_START = 2'd0;
	localparam logic [1:0] PH_DARK_READ  = 2'd1;
	localparam logic [1:0] PH_LIT_START  = 2'd2;
	localparam logic [1:0] PH_LIT_READ   = 2'd3;

	localparam logic [1:0] SENSOR_FR = 2'd0;
	localparam logic [1:0] SENSOR_SR = 2'd1;
	localparam logic [1:0] SENSOR_SL = 2'd2;
	localparam logic [1:0] SENSOR_FL = 2'd3;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] left_thr;
		logic [CFG_DATA_W-1:0] right_thr;
		logic [CFG_DATA_W-1:0] front_thr;
		logic [CFG_DATA_W-1:0] left_target;
		logic [CFG_DATA_W-1:0] right_target;
	} cfg_t;

	typedef struct packed {
		logic                    left_wall;
		logic                    right_wall;
		logic                    front_wall;
		logic                    err_update;
		logic signed [ERR_W-1:0] err;
	} refresh_t;

endpackage

>>> rtl/irws_cfg_regs.sv
// Configuration register file for the IR wall sensor sequencer.
`timescale 1ns / 1ps
module irws_cfg_regs
	import irws_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_thr     <= THRESHOLD_RESET;
			cfg_q.right_thr    <= THRESHOLD_RESET;
			cfg_q.front_thr    <= THRESHOLD_RESET;
			cfg_q.left_target  <= TARGET_RESET;
			cfg_q.right_target <= TARGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEFT_THR:     cfg_q.left_thr     <= cfg_data;
				REG_RIGHT_THR:    cfg_q.right_thr    <= cfg_data;
				REG_FRONT_THR:    cfg_q.front_thr    <= cfg_data;
				REG_LEFT_TARGET:  cfg_q.left_target  <= cfg_data;
				REG_RIGHT_TARGET: cfg_q.right_target <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/irws_refresh.sv
// Ambient correction, wall detection and steering error computation.
`timescale 1ns / 1ps
module irws_refresh
	import irws_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
)
(
	input  logic [SAMPLE_BITS-1:0] dark [4],
	input  logic [SAMPLE_BITS-1:0] lit [4],
	input  cfg_t                   cfg,
	output refresh_t               result
);

	localparam int CW = (SAMPLE_BITS > CFG_DATA_W) ? SAMPLE_BITS : CFG_DATA_W;
	localparam int EW = CW + 3;
	localparam logic signed [EW-1:0] LIM_P = EW'(ERR_LIMIT);
	localparam logic signed [EW-1:0] LIM_N = -LIM_P;

	logic [CW-1:0] corr [4];
	logic [CW-1:0] lt_x, rt_x, ft_x;
	logic [CW:0] front_sum, front_lim;
	logic signed [EW-1:0] lerr, rerr, err_raw, err_clamped;
	logic fr_over, fl_over;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			corr[k] = (dark[k] > lit[k]) ? '0 : CW'(lit[k] - dark[k]);
		end
	end

	assign lt_x = CW'(cfg.left_thr);
	assign rt_x = CW'(cfg.right_thr);
	assign ft_x = CW'(cfg.front_thr);

	assign front_sum = {1'b0, corr[SENSOR_FR]} + {1'b0, corr[SENSOR_FL]};
	assign front_lim = {ft_x, 1'b0};
	assign fr_over   = corr[SENSOR_FR] > ft_x;
	assign fl_over   = corr[SENSOR_FL] > ft_x;

	assign lerr = $signed(EW'(cfg.left_target)) - $signed(EW'(corr[SENSOR_SL]));
	assign rerr = $signed(EW'(cfg.right_target)) - $signed(EW'(corr[SENSOR_SR]));

	always_comb begin
		result.left_wall  = corr[SENSOR_SL] > lt_x;
		result.right_wall = corr[SENSOR_SR] > rt_x;
		result.front_wall = front_sum > front_lim;

		if (result.left_wall && result.right_wall) begin
			err_raw = lerr - rerr;
		end else if (result.left_wall) begin
			err_raw = lerr <<< 1;
		end else begin
			err_raw = -(rerr <<< 1);
		end

		if (err_raw > LIM_P) begin
			err_clamped = LIM_P;
		end else if (err_raw < LIM_N) begin
			err_clamped = LIM_N;
		end else begin
			err_clamped = err_raw;
		end

		if (fr_over && fl_over) begin
			result.err_update = 1'b1;
			result.err        = '0;
		end else begin
			result.err_update = result.left_wall || result.right_wall;
			result.err        = ERR_W'(err_clamped);
		end
	end

endmodule

>>> rtl/ir_wall_sensor_sequencer_unit.sv
// Top level of the IR wall sensor sequencer: input stage, phase sequencer and result register.
//
// Channel   Handshake            Payload
// in        in_valid / in_stall  adc_sample
// out       out_valid / out_stall emitter_mask adc_start left_wall right_wall front_wall
//                                steer_error round_done
// cfg       cfg_valid / cfg_ready cfg_index cfg_data
//
// Each beat passes an input register and then a result register; one beat per cycle is
// sustained while out_stall is low.
// The result register doubles as the sequencer state, so a stalled result holds still
// while one more input beat waits in the input register.
// Reset puts the sequencer at the dark conversion of sensor FR with all emitters off.
`timescale 1ns / 1ps
module ir_wall_sensor_sequencer_unit
	import irws_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
)
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SAMPLE_BITS-1:0]  adc_sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [3:0]              emitter_mask,
	output logic                    adc_start,
	output logic                    left_wall,
	output logic                    right_wall,
	output logic                    front_wall,
	output logic signed [ERR_W-1:0] steer_error,
	output logic                    round_done,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t cfg;
	refresh_t refr;

	logic                    valid_s1;
	logic [SAMPLE_BITS-1:0]  sample_s1;
	logic                    out_valid_q;
	logic [1:0]              phase_q;
	logic [1:0]              sensor_q;
	logic [SAMPLE_BITS-1:0]  dark_q [4];
	logic [SAMPLE_BITS-1:0]  lit_q [4];
	logic [SAMPLE_BITS-1:0]  lit_next [4];
	logic [3:0]              emit_q;
	logic                    left_q, right_q, front_q;
	logic signed [ERR_W-1:0] err_q;
	logic                    start_q, done_q;
	logic                    process;
	logic                    accept;
	logic [3:0]              sensor_bit;

	irws_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			lit_next[k] = (sensor_q == 2'(k)) ? sample_s1 : lit_q[k];
		end
	end

	irws_refresh #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_refresh (
		.dark   (dark_q),
		.lit    (lit_next),
		.cfg    (cfg),
		.result (refr)
	);

	assign process    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !process;
	assign accept     = in_valid && !in_stall;
	assign sensor_bit = 4'b0001 << sensor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= adc_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= PH_DARK_START;
			sensor_q    <= SENSOR_FR;
			emit_q      <= '0;
			left_q      <= 1'b0;
			right_q     <= 1'b0;
			front_q     <= 1'b0;
			err_q       <= '0;
			start_q     <= 1'b0;
			done_q      <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				dark_q[k] <= '0;
				lit_q[k]  <= '0;
			end
		end else begin
			if (process) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (process) begin
				start_q <= 1'b0;
				done_q  <= 1'b0;
				unique case (phase_q)
					PH_DARK_START: begin
						start_q <= 1'b1;
						phase_q <= PH_DARK_READ;
					end
					PH_DARK_READ: begin
						dark_q[sensor_q] <= sample_s1;
						emit_q           <= emit_q | sensor_bit;
						phase_q          <= PH_LIT_START;
					end
					PH_LIT_START: begin
						start_q <= 1'b1;
						phase_q <= PH_LIT_READ;
					end
					PH_LIT_READ: begin
						lit_q[sensor_q] <= sample_s1;
						emit_q          <= emit_q & ~sensor_bit;
						phase_q         <= PH_DARK_START;
						done_q          <= (sensor_q == SENSOR_FL);
						sensor_q        <= sensor_q + 2'd1;
						left_q          <= refr.left_wall;
						right_q         <= refr.right_wall;
						front_q         <= refr.front_wall;
						if (refr.err_update) begin
							err_q <= refr.err;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign emitter_mask = emit_q;
	assign adc_start    = start_q;
	assign left_wall    = left_q;
	assign right_wall   = right_q;
	assign front_wall   = front_q;
	assign steer_error  = err_q;
	assign round_done   = done_q;

	a_one_emitter: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(emit_q))
		else $error("More than one emitter is lit.");

	a_dark_phase_unlit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DARK_START || phase_q == PH_DARK_READ) |-> emit_q == 4'b0000)
		else $error("An emitter is lit during a dark phase.");

	a_lit_phase_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LIT_START || phase_q == PH_LIT_READ) |-> emit_q == sensor_bit)
		else $error("The current sensor's emitter is not the one lit.");

	a_start_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(start_q && done_q))
		else $error("A conversion start and a round end share one beat.");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		err_q >= -$signed(ERR_W'(ERR_LIMIT)))
		else $error("Steering error is below its limit.");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the IR wall sensor sequencer: directed table, then randomized rounds.
`timescale 1ns / 1ps
module testbench
	import irws_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_TICKS    = 75;

	typedef struct packed {
		logic [3:0]              emitter_mask;
		logic                    adc_start;
		logic                    left_wall;
		logic                    right_wall;
		logic                    front_wall;
		logic signed [ERR_W-1:0] steer_error;
		logic                    round_done;
	} sensor_frame_t;

	typedef struct {
		logic [11:0]   sample;
		bit            literal;
		sensor_frame_t frame;
	} dir_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [11:0]             adc_sample = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [3:0]              emitter_mask;
	logic                    adc_start;
	logic                    left_wall;
	logic                    right_wall;
	logic                    front_wall;
	logic signed [ERR_W-1:0] steer_error;
	logic                    round_done;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	ir_wall_sensor_sequencer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.adc_sample   (adc_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.emitter_mask (emitter_mask),
		.adc_start    (adc_start),
		.left_wall    (left_wall),
		.right_wall   (right_wall),
		.front_wall   (front_wall),
		.steer_error  (steer_error),
		.round_done   (round_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow copy of the sequencer state and register file.
	cfg_t                    shadow_cfg;
	logic [1:0]              shadow_phase;
	logic [1:0]              shadow_sensor;
	logic [11:0]             shadow_dark [4];
	logic [11:0]             shadow_lit [4];
	logic [3:0]              shadow_emitters;
	logic signed [ERR_W-1:0] shadow_error;
	logic                    shadow_left, shadow_right, shadow_front;

	sensor_frame_t pending_frames [$];
	sensor_frame_t expected_frame;
	dir_row_t      dir_rows [$];

	int mismatches = 0;
	int ticks_sent = 0;
	int rounds_done = 0;
	int front_cancels = 0;
	int side_refreshes = 0;
	int reg_writes = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_count = 0;

	function automatic int corrected_level(input logic [1:0] k);
		return (shadow_dark[k] > shadow_lit[k]) ? 0 : int'(shadow_lit[k]) - int'(shadow_dark[k]);
	endfunction

	task automatic advance_sequencer(input logic [11:0] s, output sensor_frame_t f);
		int fr, sr, sl, fl, lerr, rerr, e;
		logic start, done;
		start = 1'b0;
		done = 1'b0;
		case (shadow_phase)
			PH_DARK_START: begin
				start = 1'b1;
				shadow_phase = PH_DARK_READ;
			end
			PH_DARK_READ: begin
				shadow_dark[shadow_sensor] = s;
				shadow_emitters[shadow_sensor] = 1'b1;
				shadow_phase = PH_LIT_START;
			end
			PH_LIT_START: begin
				start = 1'b1;
				shadow_phase = PH_LIT_READ;
			end
			default: begin
				shadow_lit[shadow_sensor] = s;
				shadow_emitters[shadow_sensor] = 1'b0;
				shadow_phase = PH_DARK_START;
				done = (shadow_sensor == SENSOR_FL);
				shadow_sensor = shadow_sensor + 2'd1;
				fr = corrected_level(SENSOR_FR);
				sr = corrected_level(SENSOR_SR);
				sl = corrected_level(SENSOR_SL);
				fl = corrected_level(SENSOR_FL);
				lerr = int'(shadow_cfg.left_target) - sl;
				rerr = int'(shadow_cfg.right_target) - sr;
				shadow_left = sl > int'(shadow_cfg.left_thr);
				shadow_right = sr > int'(shadow_cfg.right_thr);
				shadow_front = (fr + fl) > 2 * int'(shadow_cfg.front_thr);
				e = int'(shadow_error);
				if (shadow_left && shadow_right)
					e = lerr - rerr;
				else if (shadow_left)
					e = 2 * lerr;
				else if (shadow_right)
					e = -2 * rerr;
				if (shadow_left || shadow_right)
					side_refreshes++;
				if (e > ERR_LIMIT)
					e = ERR_LIMIT;
				if (e < -ERR_LIMIT)
					e = -ERR_LIMIT;
				if (fr > int'(shadow_cfg.front_thr) && fl > int'(shadow_cfg.front_thr)) begin
					e = 0;
					front_cancels++;
				end
				shadow_error = e[ERR_W-1:0];
				if (done)
					rounds_done++;
			end
		endcase
		f.emitter_mask = shadow_emitters;
		f.adc_start = start;
		f.left_wall = shadow_left;
		f.right_wall = shadow_right;
		f.front_wall = shadow_front;
		f.steer_error = shadow_error;
		f.round_done = done;
	endtask

	function automatic sensor_frame_t make_frame(input logic [3:0] mask, input logic start,
		input logic lw, input logic rw, input logic fw, input int err, input logic done);
		sensor_frame_t f;
		f.emitter_mask = mask;
		f.adc_start = start;
		f.left_wall = lw;
		f.right_wall = rw;
		f.front_wall = fw;
		f.steer_error = err[ERR_W-1:0];
		f.round_done = done;
		return f;
	endfunction

	task automatic add_row(input logic [11:0] s, input bit literal, input sensor_frame_t f);
		dir_row_t r;
		r.sample = s;
		r.literal = literal;
		r.frame = f;
		dir_rows.push_back(r);
	endtask

	// Picks a sample aimed at the phase the next beat will land in.
	function automatic logic [11:0] next_sample();
		int thr, v;
		case (shadow_sensor)
			SENSOR_SL: thr = int'(shadow_cfg.left_thr);
			SENSOR_SR: thr = int'(shadow_cfg.right_thr);
			default: thr = int'(shadow_cfg.front_thr);
		endcase
		if (shadow_phase == PH_DARK_READ) begin
			v = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 400)) : int'($urandom_range(0, 4095));
		end else if (shadow_phase == PH_LIT_READ) begin
			case ($urandom_range(0, 5))
				0: v = int'(shadow_dark[shadow_sensor]) + thr + int'($urandom_range(0, 4)) - 2;
				1: v = 0;
				2: v = 4095;
				3: v = int'($urandom_range(0, 4095));
				default: v = int'($urandom_range(0, 2600));
			endcase
		end else begin
			v = int'($urandom_range(0, 4095));
		end
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	task automatic send_item(input logic [11:0] s, input bit literal, input sensor_frame_t f);
		sensor_frame_t predicted;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		adc_sample <= s;
		do @(posedge clk); while (in_stall);
		advance_sequencer(s, predicted);
		pending_frames.push_back(literal ? f : predicted);
		ticks_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		case (idx)
			REG_LEFT_THR: shadow_cfg.left_thr = d;
			REG_RIGHT_THR: shadow_cfg.right_thr = d;
			REG_FRONT_THR: shadow_cfg.front_thr = d;
			REG_LEFT_TARGET: shadow_cfg.left_target = d;
			REG_RIGHT_TARGET: shadow_cfg.right_target = d;
			default: ;
		endcase
	endtask

	// Writes all five registers plus one write to an unmapped index, which must be ignored.
	task automatic apply_setting(input int lt, input int rt, input int ft, input int ltg, input int rtg);
		logic [CFG_IDX_W-1:0] spare;
		spare = CFG_IDX_W'($urandom_range(5, 7));
		write_reg(REG_LEFT_THR, lt[11:0]);
		write_reg(REG_RIGHT_THR, rt[11:0]);
		write_reg(spare, CFG_DATA_W'($urandom_range(0, 4095)));
		write_reg(REG_FRONT_THR, ft[11:0]);
		write_reg(REG_LEFT_TARGET, ltg[11:0]);
		write_reg(REG_RIGHT_TARGET, rtg[11:0]);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_frames.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int exp, input int act);
		if (exp != act) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: result beat arrived with no expected result pending", $time);
				mismatches++;
			end else begin
				expected_frame = pending_frames.pop_front();
				check_field("emitter_mask", expected_frame.emitter_mask, emitter_mask);
				check_field("adc_start", expected_frame.adc_start, adc_start);
				check_field("left_wall", expected_frame.left_wall, left_wall);
				check_field("right_wall", expected_frame.right_wall, right_wall);
				check_field("front_wall", expected_frame.front_wall, front_wall);
				check_field("steer_error", int'(expected_frame.steer_error), int'(steer_error));
				check_field("round_done", expected_frame.round_done, round_done);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_count == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_count <= $urandom_range(20, 80);
		end else begin
			stall_count <= stall_count - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 6);
			default: out_stall <= (stall_count % 5) < 2;
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("ir_wall_sensor_sequencer_unit regression: fail");
			$finish;
		end
	end

	initial begin
		shadow_cfg.left_thr = THRESHOLD_RESET;
		shadow_cfg.right_thr = THRESHOLD_RESET;
		shadow_cfg.front_thr = THRESHOLD_RESET;
		shadow_cfg.left_target = TARGET_RESET;
		shadow_cfg.right_target = TARGET_RESET;
		shadow_phase = PH_DARK_START;
		shadow_sensor = SENSOR_FR;
		for (int k = 0; k < 4; k++) begin
			shadow_dark[k] = '0;
			shadow_lit[k] = '0;
		end
		shadow_emitters = '0;
		shadow_error = '0;
		shadow_left = 1'b0;
		shadow_right = 1'b0;
		shadow_front = 1'b0;

		// The first round after reset uses the reset thresholds, so its early beats are typed in.
		add_row(12'hFFF, 1, make_frame(4'h0, 1, 0, 0, 0, 0, 0));
		add_row(12'h000, 1, make_frame(4'h1, 0, 0, 0, 0, 0, 0));
		add_row(12'hFFF, 1, make_frame(4'h1, 1, 0, 0, 0, 0, 0));
		add_row(12'hFFF, 1, make_frame(4'h0, 0, 0, 0, 1, 0, 0));
		add_row(12'h555, 1, make_frame(4'h0, 1, 0, 0, 1, 0, 0));
		add_row(12'hFFF, 1, make_frame(4'h2, 0, 0, 0, 1, 0, 0));
		add_row(12'hAAA, 1, make_frame(4'h2, 1, 0, 0, 1, 0, 0));
		add_row(12'h000, 1, make_frame(4'h0, 0, 0, 0, 1, 0, 0));
		add_row(12'h123, 0, '0);
		add_row(12'h000, 0, '0);
		add_row(12'hFFF, 0, '0);
		add_row(12'hFFF, 0, '0);
		add_row(12'hABC, 0, '0);
		add_row(12'h000, 0, '0);
		add_row(12'hFFF, 0, '0);
		add_row(12'hFFF, 0, '0);
		add_row(12'h000, 0, '0);
		add_row(12'hFFF, 0, '0);
		add_row(12'h000, 0, '0);
		add_row(12'hFFF, 0, '0);
		add_row(12'hFFF, 0, '0);
		add_row(12'h000, 0, '0);
		add_row(12'h555, 0, '0);
		add_row(12'h7D0, 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].sample, dir_rows[i].literal, dir_rows[i].frame);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			in_valid <= 1'b0;
			wait_drained();
			case (p)
				0: apply_setting(0, 0, 0, 0, 0);
				1: apply_setting(4095, 4095, 4095, 4095, 4095);
				2: apply_setting(800, 800, 800, 1400, 1400);
				3: apply_setting($urandom_range(200, 1500), $urandom_range(200, 1500),
					$urandom_range(200, 1500), $urandom_range(500, 3000), $urandom_range(500, 3000));
				default: apply_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
			endcase
			for (int n = 0; n < PHASE_TICKS; n++)
				send_item(next_sample(), 0, '0);
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Covered %0d sensor ticks in %0d full rounds across %0d register writes.",
			ticks_sent, rounds_done, reg_writes);
		$display("Side walls steered %0d refreshes; front cancel fired %0d times; %0d mismatches.",
			side_refreshes, front_cancels, mismatches);
		if (mismatches == 0 && pending_frames.size() == 0) begin
			$display("ir_wall_sensor_sequencer_unit regression: pass");
		end else begin
			$display("ir_wall_sensor_sequencer_unit regression: fail");
		end
		$finish;
	end

endmodule
